>>> hw/rtl/vln_pkg.sv
`timescale 1ns / 1ps
// Shared constants, command and status types, and the seed table for the vector normalizer.
package vln_pkg;

  localparam int MAX_LENGTH = 1024;
  localparam int ELEM_W     = 16;
  localparam int INDEX_W    = 10;
  localparam int COUNT_W    = $clog2(MAX_LENGTH + 1);
  localparam int ADDR_W     = $clog2(MAX_LENGTH);
  localparam int SUM_W      = 40;
  localparam int SHIFT_W    = 5;
  localparam int OP_W       = 5;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_PUSH  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [OP_W-1:0] OP_NOP       = 5'd0;
  localparam logic [OP_W-1:0] OP_CLEAR     = 5'd1;
  localparam logic [OP_W-1:0] OP_STORE     = 5'd2;
  localparam logic [OP_W-1:0] OP_ACCUM     = 5'd3;
  localparam logic [OP_W-1:0] OP_OVERFLOW  = 5'd4;
  localparam logic [OP_W-1:0] OP_INV_ZERO  = 5'd5;
  localparam logic [OP_W-1:0] OP_NORM_LOAD = 5'd6;
  localparam logic [OP_W-1:0] OP_NORM_STEP = 5'd7;
  localparam logic [OP_W-1:0] OP_SEED      = 5'd8;
  localparam logic [OP_W-1:0] OP_MUL_YY    = 5'd9;
  localparam logic [OP_W-1:0] OP_MUL_MY    = 5'd10;
  localparam logic [OP_W-1:0] OP_HALF      = 5'd11;
  localparam logic [OP_W-1:0] OP_MUL_YH    = 5'd12;
  localparam logic [OP_W-1:0] OP_Y_UPDATE  = 5'd13;
  localparam logic [OP_W-1:0] OP_Y_FINAL   = 5'd14;
  localparam logic [OP_W-1:0] OP_READ_MUL  = 5'd15;
  localparam logic [OP_W-1:0] OP_ROUND     = 5'd16;
  localparam logic [OP_W-1:0] OP_EMIT      = 5'd17;

  typedef struct packed {
    logic            load;
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       sum_zero;
    logic       count_full;
    logic       inv_valid;
    logic       norm_done;
  } status_t;

  // Q0.16 inverse root at the midpoint of each eighth-wide mantissa interval.
  function automatic logic [15:0] rsqrt_seed(input logic [4:0] idx);
    logic [15:0] seed;
    seed = 16'd0;
    case (idx)
      5'd9:  seed = 16'd60140;
      5'd10: seed = 16'd57205;
      5'd11: seed = 16'd54661;
      5'd12: seed = 16'd52429;
      5'd13: seed = 16'd50449;
      5'd14: seed = 16'd48679;
      5'd15: seed = 16'd47082;
      5'd16: seed = 16'd45634;
      5'd17: seed = 16'd44310;
      5'd18: seed = 16'd43096;
      5'd19: seed = 16'd41977;
      5'd20: seed = 16'd40940;
      5'd21: seed = 16'd39977;
      5'd22: seed = 16'd39078;
      5'd23: seed = 16'd38238;
      5'd24: seed = 16'd37449;
      5'd25: seed = 16'd36708;
      5'd26: seed = 16'd36008;
      5'd27: seed = 16'd35348;
      5'd28: seed = 16'd34722;
      5'd29: seed = 16'd34128;
      5'd30: seed = 16'd33564;
      5'd31: seed = 16'd33027;
      default: seed = 16'd63579;
    endcase
    return seed;
  endfunction

endpackage

>>> hw/rtl/vln_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences clear, push, inverse-root and read operations.
module vln_ctrl
  import vln_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    done
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_DISPATCH   = 4'd1;
  localparam logic [3:0] S_ACCUM      = 4'd2;
  localparam logic [3:0] S_NORM       = 4'd3;
  localparam logic [3:0] S_NEWTON_YY  = 4'd4;
  localparam logic [3:0] S_NEWTON_MY  = 4'd5;
  localparam logic [3:0] S_NEWTON_H   = 4'd6;
  localparam logic [3:0] S_NEWTON_YH  = 4'd7;
  localparam logic [3:0] S_NEWTON_UPD = 4'd8;
  localparam logic [3:0] S_READ_MUL   = 4'd9;
  localparam logic [3:0] S_READ_ROUND = 4'd10;
  localparam logic [3:0] S_READ_EMIT  = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       pass;
  logic       pass_next;

  always_comb begin
    state_next = state;
    pass_next  = pass;
    cmd.load   = 1'b0;
    cmd.op     = OP_NOP;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        pass_next = 1'b0;
        unique case (status.action)
          ACT_CLEAR: begin
            cmd.op     = OP_CLEAR;
            state_next = S_IDLE;
          end
          ACT_PUSH: begin
            if (status.count_full) begin
              cmd.op     = OP_OVERFLOW;
              state_next = S_IDLE;
            end else begin
              cmd.op     = OP_STORE;
              state_next = S_ACCUM;
            end
          end
          ACT_READ: begin
            if (status.inv_valid) begin
              state_next = S_READ_MUL;
            end else if (status.sum_zero) begin
              cmd.op     = OP_INV_ZERO;
              state_next = S_READ_MUL;
            end else begin
              cmd.op     = OP_NORM_LOAD;
              state_next = S_NORM;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_ACCUM: begin
        cmd.op     = OP_ACCUM;
        state_next = S_IDLE;
      end
      S_NORM: begin
        if (status.norm_done) begin
          cmd.op     = OP_SEED;
          state_next = S_NEWTON_YY;
        end else begin
          cmd.op = OP_NORM_STEP;
        end
      end
      S_NEWTON_YY: begin
        cmd.op     = OP_MUL_YY;
        state_next = S_NEWTON_MY;
      end
      S_NEWTON_MY: begin
        cmd.op     = OP_MUL_MY;
        state_next = S_NEWTON_H;
      end
      S_NEWTON_H: begin
        cmd.op     = OP_HALF;
        state_next = S_NEWTON_YH;
      end
      S_NEWTON_YH: begin
        cmd.op     = OP_MUL_YH;
        state_next = S_NEWTON_UPD;
      end
      S_NEWTON_UPD: begin
        // The second pass closes the inverse root and moves on to the read.
        pass_next = !pass;
        if (pass) begin
          cmd.op     = OP_Y_FINAL;
          state_next = S_READ_MUL;
        end else begin
          cmd.op     = OP_Y_UPDATE;
          state_next = S_NEWTON_YY;
        end
      end
      S_READ_MUL: begin
        cmd.op     = OP_READ_MUL;
        state_next = S_READ_ROUND;
      end
      S_READ_ROUND: begin
        cmd.op     = OP_ROUND;
        state_next = S_READ_EMIT;
      end
      S_READ_EMIT: begin
        cmd.op     = OP_EMIT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pass  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
      done  <= (state == S_READ_EMIT);
    end
  end

  assign busy = (state != S_IDLE);

endmodule

>>> hw/rtl/vln_datapath.sv
`timescale 1ns / 1ps
// Datapath: element store, running square sum, shared multiplier and inverse-root registers.
module vln_datapath
  import vln_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  input  logic [1:0]                action,
  input  logic signed [ELEM_W-1:0]  element_value,
  input  logic [INDEX_W-1:0]        read_index,
  output status_t                   status,
  output logic signed [ELEM_W-1:0]  normalized_value,
  output logic [INDEX_W-1:0]        echo_index,
  output logic                      zero_norm,
  output logic                      bad_access
);

  localparam logic [33:0] THREE_Q30 = 34'(3) << 30;

  logic [ELEM_W-1:0]  mem [MAX_LENGTH];
  logic [ELEM_W-1:0]  rdata;

  logic [1:0]         action_q;
  logic [ELEM_W-1:0]  elem_q;
  logic [INDEX_W-1:0] index_q;

  logic [COUNT_W-1:0] count;
  logic [SUM_W-1:0]   sum;
  logic               overflow_seen;
  logic               inv_valid;

  logic [SUM_W-1:0]   x;
  logic [SHIFT_W-1:0] k;
  logic [31:0]        y;
  logic [31:0]        h;
  logic [63:0]        prod;
  logic [31:0]        q;

  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        mul_p;
  logic               mul_en;
  logic [ELEM_W:0]    elem_mag;
  logic [ELEM_W:0]    rd_mag;
  logic [SUM_W:0]     sum_add;
  logic [33:0]        t;
  logic [5:0]         sh;
  logic [63:0]        rounded;
  logic [63:0]        shifted;
  logic               read_ok;
  logic [15:0]        pos_val;
  logic [16:0]        neg_mag;
  logic [15:0]        neg_val;

  assign elem_mag = elem_q[ELEM_W-1] ? (~{elem_q[ELEM_W-1], elem_q} + 1'b1)
                                     : {1'b0, elem_q};
  assign rd_mag   = rdata[ELEM_W-1] ? (~{rdata[ELEM_W-1], rdata} + 1'b1)
                                    : {1'b0, rdata};

  // One shared multiplier. The inverse root y stays at or below 1.0 and h at or below 3.0
  // in Q2.30, so the y*y and y*h operands fit in 32 bits.
  always_comb begin
    mul_a  = 32'd0;
    mul_b  = 32'd0;
    mul_en = 1'b1;
    case (cmd.op)
      OP_STORE: begin
        mul_a = 32'(elem_mag);
        mul_b = 32'(elem_mag);
      end
      OP_MUL_YY: begin
        mul_a = y;
        mul_b = y;
      end
      OP_MUL_MY: begin
        mul_a = x[31:0];
        mul_b = prod[61:30];
      end
      OP_MUL_YH: begin
        mul_a = y;
        mul_b = h;
      end
      OP_READ_MUL: begin
        mul_a = 32'(rd_mag);
        mul_b = y;
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign sum_add = {1'b0, sum} + {{(SUM_W - 30){1'b0}}, prod[30:0]};
  assign t       = prod[63:30];
  assign sh      = 6'd15 + 6'(k);
  assign rounded = prod + (64'd1 << (sh - 6'd1));
  assign shifted = rounded >> sh;

  assign read_ok = ({1'b0, index_q} < count) && (sum != '0);
  assign pos_val = (q > 32'd32767) ? 16'd32767 : q[15:0];
  assign neg_mag = (q > 32'd32768) ? 17'd32768 : q[16:0];
  assign neg_val = 16'(~neg_mag + 17'd1);

  assign status.action     = action_q;
  assign status.sum_zero   = (sum == '0);
  assign status.count_full = (count == COUNT_W'(MAX_LENGTH));
  assign status.inv_valid  = inv_valid;
  assign status.norm_done  = (x[SUM_W-1:32] == '0) && (x[31:30] != 2'b00);

  always_ff @(posedge clk) begin
    if (cmd.op == OP_STORE) begin
      mem[count[ADDR_W-1:0]] <= elem_q;
    end
    rdata <= mem[index_q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      sum           <= '0;
      overflow_seen <= 1'b0;
      inv_valid     <= 1'b0;
    end else begin
      case (cmd.op)
        OP_CLEAR: begin
          count         <= '0;
          sum           <= '0;
          overflow_seen <= 1'b0;
          inv_valid     <= 1'b0;
        end
        OP_ACCUM: begin
          count     <= count + 1'b1;
          sum       <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
          inv_valid <= 1'b0;
        end
        OP_OVERFLOW: overflow_seen <= 1'b1;
        OP_INV_ZERO: inv_valid     <= 1'b1;
        OP_Y_FINAL:  inv_valid     <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_q <= action;
      elem_q   <= element_value;
      index_q  <= read_index;
    end
    if (mul_en) begin
      prod <= mul_p;
    end
    case (cmd.op)
      OP_INV_ZERO: begin
        y <= 32'd0;
        k <= '0;
      end
      OP_NORM_LOAD: begin
        x <= sum;
        k <= SHIFT_W'(15);
      end
      OP_NORM_STEP: begin
        // Bring the sum into [1,4) in Q2.30 two bits at a time.
        if (x[SUM_W-1:32] != '0) begin
          x <= x >> 2;
          k <= k + 1'b1;
        end else begin
          x <= x << 2;
          k <= k - 1'b1;
        end
      end
      OP_SEED:     y <= {2'b00, rsqrt_seed(x[31:27]), 14'd0};
      OP_HALF:     h <= (t < THREE_Q30) ? 32'(THREE_Q30 - t) : 32'd0;
      OP_Y_UPDATE: y <= prod[62:31];
      OP_Y_FINAL:  y <= prod[62:31];
      OP_ROUND:    q <= shifted[31:0];
      OP_EMIT: begin
        echo_index <= index_q;
        zero_norm  <= (sum == '0);
        bad_access <= overflow_seen || ({1'b0, index_q} >= count);
        if (read_ok) begin
          normalized_value <= rdata[ELEM_W-1] ? neg_val : pos_val;
        end else begin
          normalized_value <= '0;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/vector_l2_normalizer.sv
`timescale 1ns / 1ps
// Vector L2 normalizer. Busy covers only dispatch for a clear, an unused action or a dropped
// push; a stored push adds an accumulate step. A read with a current inverse root runs the
// read multiply, round and emit steps, and done pulses once the sequencer is back in idle.
// The first read after a push that leaves a nonzero sum runs up to 15 normalizing shifts and
// the seed, then two Newton passes on the one shared multiplier. The receiver cannot stall.
// Synchronous reset empties the vector; the element store itself is not cleared.
module vector_l2_normalizer
  import vln_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                action,
  input  logic signed [ELEM_W-1:0]  element_value,
  input  logic [INDEX_W-1:0]        read_index,
  output logic                      done,
  output logic signed [ELEM_W-1:0]  normalized_value,
  output logic [INDEX_W-1:0]        echo_index,
  output logic                      zero_norm,
  output logic                      bad_access
);

  cmd_t    cmd;
  status_t status;

  vln_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  vln_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .action           (action),
    .element_value    (element_value),
    .read_index       (read_index),
    .status           (status),
    .normalized_value (normalized_value),
    .echo_index       (echo_index),
    .zero_norm        (zero_norm),
    .bad_access       (bad_access)
  );

  // A word is delivered only after the sequencer has returned to idle.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // Each read yields a single one-cycle strobe.
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  // An accepted word always starts work.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted word did not start the sequencer");

  // A zero sum of squares forces a zero result.
  assert property (@(posedge clk) disable iff (rst)
                   (done && zero_norm) |-> (normalized_value == '0))
    else $error("nonzero value with zero norm");

endmodule
